// ===== src/look_disk_request_scheduler_defines.svh =====
// assertion macros for the look disk request scheduler
// expects clk and rst in the scope of each use
`ifndef LOOK_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define LOOK_DISK_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LDRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LDRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LDRS_ASSERT_IMP(lbl, ante, cons, msg)
`define LDRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/ldrs_pkg.sv =====
// shared constants, types and register codes of the look disk request scheduler
// no dependencies
`default_nettype none

package ldrs_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int TRACK_BITS    = 12;
  localparam int SUM_BITS      = TRACK_BITS + 1;
  localparam int IDX_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int SIDX_BITS     = 5;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 12;
  localparam int START_TRACK_RESET = 50;

  localparam int IN_TDATA_BITS  = ((TRACK_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * TRACK_BITS + SUM_BITS + SIDX_BITS + 1;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_TRACK = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_DIR   = 1'd1;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  // nearest pending request on each side of the head
  typedef struct packed {
    logic   below_found;
    track_t below_track;
    idx_t   below_idx;
    logic   above_found;
    track_t above_track;
    idx_t   above_idx;
  } best_t;

endpackage

`default_nettype wire

// ===== src/ldrs_store.sv =====
// request track memory: one write port, one read port with registered data
// depends on ldrs_pkg
`default_nettype none

module ldrs_store
  import ldrs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   wr_en,
  input  wire idx_t   wr_addr,
  input  wire track_t wr_data,
  input  wire logic   rd_en,
  input  wire idx_t   rd_addr,
  output track_t      rd_data
);

  track_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ldrs_pick.sv =====
// shared comparator that tracks the nearest pending request below and above the head
// one memory word per cycle; depends on ldrs_pkg
`default_nettype none

module ldrs_pick
  import ldrs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   clr,
  input  wire logic   vld,
  input  wire logic   pend,
  input  wire idx_t   idx,
  input  wire track_t track,
  input  wire track_t head,
  output best_t       best
);

  logic take_below;
  logic take_above;

  // strict compares keep the lowest slot among equal tracks
  assign take_below = (track <= head) && (!best.below_found || (track > best.below_track));
  assign take_above = (track >= head) && (!best.above_found || (track < best.above_track));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      best.below_found <= 1'b0;
      best.above_found <= 1'b0;
    end else if (vld && pend) begin
      if (take_below) begin
        best.below_found <= 1'b1;
        best.below_track <= track;
        best.below_idx   <= idx;
      end
      if (take_above) begin
        best.above_found <= 1'b1;
        best.above_track <= track;
        best.above_idx   <= idx;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/look_disk_request_scheduler.sv =====
// LOOK elevator disk request scheduler. Requests are loaded one per cycle into a
// 16-entry track memory until a request with tlast arrives; requests past the queue
// depth are dropped and flagged. The batch is then served in LOOK order from the
// configured start track and direction, one result per request. For each served
// request, the single read port of the track memory is swept over all loaded
// entries through one shared comparator, a drain state lets the last read word
// reach the comparator, and then the pick state, once the output register is free,
// picks the entry and loads the output register. No new request is taken until the
// last result of the batch has been placed in the output register.
// depends on ldrs_pkg, ldrs_store, ldrs_pick and the assertion macro header
`default_nettype none

`include "look_disk_request_scheduler_defines.svh"

module look_disk_request_scheduler
  import ldrs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // request_track, zero padded
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // batch_end
  input  wire logic                      s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // served_track, move_distance, total_movement, served_index, overflow, zero padded
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
  // final_service
  output logic                           m_axis_tlast
);

  typedef enum logic [1:0] {S_LOAD, S_SCAN, S_DRAIN, S_PICK} state_t;

  state_t                     state;
  logic [CFG_DATA_BITS-1:0]   start_track;
  logic                       start_dir;
  logic [CNT_BITS-1:0]        loaded_count;
  logic [CNT_BITS-1:0]        serve_count;
  logic [QUEUE_DEPTH-1:0]     pending_mask;
  track_t                     head;
  logic [SUM_BITS-1:0]        msum;
  logic                       sweep_down;
  logic                       dropped;
  idx_t                       scan_addr;
  logic                       rd_valid;
  idx_t                       rd_idx;
  track_t                     rd_track;

  track_t                     out_track;
  track_t                     out_dist;
  logic [SUM_BITS-1:0]        out_total;
  logic [SIDX_BITS-1:0]       out_idx;
  logic                       out_ovf;

  best_t                      best;
  logic                       in_fire;
  logic                       q_full;
  logic                       wr_en;
  logic                       scan_last;
  logic                       pick_fire;
  logic                       use_above;
  track_t                     pick_track;
  idx_t                       pick_idx;
  logic                       sweep_next;
  track_t                     move_dist;
  logic [SUM_BITS-1:0]        sum_next;
  logic [CNT_BITS-1:0]        serve_next;
  logic                       is_last;

  assign s_axis_tready = (state == S_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign q_full        = (loaded_count == CNT_BITS'(QUEUE_DEPTH));
  assign wr_en         = in_fire && !q_full;
  assign scan_last     = (scan_addr == IDX_BITS'(loaded_count - CNT_BITS'(1)));
  assign pick_fire     = (state == S_PICK) && (!m_axis_tvalid || m_axis_tready);

  // stay on the sweep side while it has a request, else turn around
  assign use_above  = sweep_down ? !best.below_found : best.above_found;
  assign pick_track = use_above ? best.above_track : best.below_track;
  assign pick_idx   = use_above ? best.above_idx : best.below_idx;
  assign sweep_next = !use_above;
  assign move_dist  = (pick_track >= head) ? (pick_track - head) : (head - pick_track);
  assign sum_next   = msum + SUM_BITS'(move_dist);
  assign serve_next = serve_count + CNT_BITS'(1);
  assign is_last    = (serve_next == loaded_count);

  assign m_axis_tdata = OUT_TDATA_BITS'({out_ovf, out_idx, out_total, out_dist, out_track});

  ldrs_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded_count[IDX_BITS-1:0]),
    .wr_data (s_axis_tdata[TRACK_BITS-1:0]),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_addr),
    .rd_data (rd_track)
  );

  ldrs_pick u_pick (
    .clk   (clk),
    .rst   (rst),
    .clr   (pick_fire || (state == S_LOAD)),
    .vld   (rd_valid),
    .pend  (pending_mask[rd_idx]),
    .idx   (rd_idx),
    .track (rd_track),
    .head  (head),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      start_track   <= CFG_DATA_BITS'(START_TRACK_RESET);
      start_dir     <= 1'b0;
      loaded_count  <= '0;
      serve_count   <= '0;
      pending_mask  <= '0;
      head          <= TRACK_BITS'(START_TRACK_RESET);
      msum          <= '0;
      sweep_down    <= 1'b0;
      dropped       <= 1'b0;
      scan_addr     <= '0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_START_TRACK: start_track <= cfg_data;
          REG_START_DIR:   start_dir   <= cfg_data[0];
          default: ;
        endcase
      end

      rd_valid <= (state == S_SCAN);
      rd_idx   <= scan_addr;

      if (pick_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (q_full) begin
              dropped <= 1'b1;
            end else begin
              pending_mask[loaded_count[IDX_BITS-1:0]] <= 1'b1;
              loaded_count <= loaded_count + CNT_BITS'(1);
            end
            if (s_axis_tlast) begin
              head        <= TRACK_BITS'(start_track);
              msum        <= '0;
              sweep_down  <= start_dir;
              serve_count <= '0;
              scan_addr   <= '0;
              state       <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= scan_addr + IDX_BITS'(1);
          end
        end
        S_DRAIN: begin
          // last read word reaches the comparator this cycle
          state <= S_PICK;
        end
        S_PICK: begin
          if (pick_fire) begin
            out_track <= pick_track;
            out_dist  <= move_dist;
            out_total <= sum_next;
            out_idx   <= SIDX_BITS'(serve_next);
            out_ovf   <= dropped;
            m_axis_tlast <= is_last;
            head        <= pick_track;
            msum        <= sum_next;
            sweep_down  <= sweep_next;
            serve_count <= serve_next;
            scan_addr   <= '0;
            if (is_last) begin
              pending_mask <= '0;
              loaded_count <= '0;
              dropped      <= 1'b0;
              state        <= S_LOAD;
            end else begin
              pending_mask[pick_idx] <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `LDRS_ASSERT_IMP(a_pick_pending, pick_fire, pending_mask[pick_idx], "picked request is not pending")
  `LDRS_ASSERT_IMP(a_pick_found, state == S_PICK, best.below_found || best.above_found, "no request found at pick")
  `LDRS_ASSERT_IMP(a_pending_count, state == S_PICK, CNT_BITS'($countones(pending_mask)) == CNT_BITS'(loaded_count - serve_count), "pending count out of step with served count")
  `LDRS_ASSERT_NXT(a_batch_done, pick_fire && is_last, (pending_mask == '0) && (state == S_LOAD), "batch not cleared after last request")

endmodule

`default_nettype wire
